// ----- rtl/core/svalloc_pkg.sv -----
// Shared constants, codes and cell command/status types for the voice allocator.
package svalloc_pkg;

  localparam int NUM_VOICES   = 16;
  localparam int NUM_CHANNELS = 16;

  localparam int ACTION_W  = 2;
  localparam int CHANNEL_W = 4;
  localparam int NOTE_W    = 7;
  localparam int CTRL_W    = 7;
  localparam int STATUS_W  = 3;
  localparam int INDEX_W   = 4;
  localparam int MASK_W    = 16;
  localparam int VIDX_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CONTROL  = 2'd2;

  localparam logic [CTRL_W-1:0] SUSTAIN_CTRL    = 7'h40;
  localparam logic [CTRL_W-1:0] PEDAL_THRESHOLD = 7'd64;

  localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_VOICE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SUSTAIN   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;

  // decoded event broadcast to every voice cell
  typedef struct packed {
    logic                 note_on;
    logic                 note_off;
    logic                 pedal_set;
    logic                 pedal_clr;
    logic                 pedal;
    logic [CHANNEL_W-1:0] channel;
    logic [NOTE_W-1:0]    note;
  } cell_cmd_t;

  typedef struct packed {
    logic dup_hit;
    logic claim;
    logic changed;
    logic sounding;
  } cell_stat_t;

endpackage

// ----- rtl/core/svalloc_evt_if.sv -----
// Event channel: MIDI-style event into the allocator.
interface svalloc_evt_if;
  import svalloc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [CHANNEL_W-1:0] channel;
  logic [NOTE_W-1:0]    note_number;
  logic [CTRL_W-1:0]    control_number;
  logic [CTRL_W-1:0]    control_value;

  modport source (output valid, action, channel, note_number, control_number,
                  control_value, input ready);
  modport sink   (input valid, action, channel, note_number, control_number,
                  control_value, output ready);
endinterface

// ----- rtl/core/svalloc_res_if.sv -----
// Result channel: one status transaction per accepted event.
interface svalloc_res_if;
  import svalloc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  voice_index;
  logic [MASK_W-1:0]   changed_mask;
  logic [MASK_W-1:0]   sounding_mask;

  modport source (output valid, status, voice_index, changed_mask, sounding_mask,
                  input ready);
  modport sink   (input valid, status, voice_index, changed_mask, sounding_mask,
                  output ready);
endinterface

// ----- rtl/core/svalloc_cell.sv -----
// One voice cell: holds a voice's marks, note and channel; passes the claim token on.
module svalloc_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   apply,
  input  svalloc_pkg::cell_cmd_t cmd,
  input  logic                   dup,
  input  logic                   taken_in,
  output logic                   taken_out,
  output svalloc_pkg::cell_stat_t stat
);
  import svalloc_pkg::*;

  logic                 pressed;
  logic                 sustained;
  logic [NOTE_W-1:0]    note;
  logic [CHANNEL_W-1:0] channel;

  logic free, chan_hit, claim, release_hit, sus_on, sus_off;
  logic pressed_next, sustained_next;

  always_comb begin
    free        = !pressed && !sustained;
    chan_hit    = (channel == cmd.channel);
    claim       = cmd.note_on && !dup && free && !taken_in;
    release_hit = cmd.note_off && pressed && (note == cmd.note) && chan_hit;
    sus_on      = cmd.pedal_set && pressed && chan_hit;
    sus_off     = cmd.pedal_clr && chan_hit;

    pressed_next = pressed;
    if (claim) begin
      pressed_next = 1'b1;
    end else if (release_hit) begin
      pressed_next = 1'b0;
    end

    sustained_next = sustained;
    if (claim) begin
      sustained_next = cmd.pedal;
    end else if (sus_on) begin
      sustained_next = 1'b1;
    end else if (sus_off) begin
      sustained_next = 1'b0;
    end
  end

  // first free cell stops the token for everything above it
  assign taken_out = taken_in || free;

  assign stat.dup_hit  = sustained && (note == cmd.note);
  assign stat.claim    = claim;
  assign stat.changed  = claim || release_hit || (sus_on && !sustained) ||
                         (sus_off && sustained);
  assign stat.sounding = pressed_next || sustained_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed   <= 1'b0;
      sustained <= 1'b0;
    end else if (apply) begin
      pressed   <= pressed_next;
      sustained <= sustained_next;
    end
  end

  always_ff @(posedge clk) begin
    if (apply && claim) begin
      note    <= cmd.note;
      channel <= cmd.channel;
    end
  end

endmodule

// ----- rtl/core/synth_voice_allocator_unit.sv -----
// Top level: voice cell chain, per-channel pedal flags and the result register.
//
//   port  dir  fields
//   evt   in   action, channel, note_number, control_number, control_value
//   res   out  status, voice_index, changed_mask, sounding_mask
//
// One event per cycle; its result is registered and shows in the cycle after accept.
// evt.ready is high while the result register is empty or being taken.
// Cycle time is set by the free-voice priority chain through the NUM_VOICES cells.
// A stalled result holds evt off; nothing else stalls.
// rst clears all voice marks, all pedals and the result register.
module synth_voice_allocator_unit (
  input logic          clk,
  input logic          rst,
  svalloc_evt_if.sink  evt,
  svalloc_res_if.source res
);
  import svalloc_pkg::*;

  logic [NUM_CHANNELS-1:0] pedal_down;
  logic                    accept;
  logic                    chan_ok;
  logic                    pedal_cur;
  logic                    ctl_sustain;
  logic                    pedal_val;
  cell_cmd_t               cmd;
  logic                    dup;
  logic [NUM_VOICES:0]     taken;
  cell_stat_t              stat [NUM_VOICES];
  logic [VIDX_W-1:0]       pick;
  logic [STATUS_W-1:0]     status_next;
  logic [MASK_W-1:0]       changed_next;
  logic [MASK_W-1:0]       sounding_next;

  assign evt.ready = !res.valid || res.ready;
  assign accept    = evt.valid && evt.ready;

  always_comb begin
    chan_ok   = ({1'b0, evt.channel} < (CHANNEL_W+1)'(NUM_CHANNELS));
    pedal_cur = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (evt.channel == CHANNEL_W'(c)) begin
        pedal_cur = pedal_down[c];
      end
    end
    ctl_sustain = (evt.action == ACT_CONTROL) && (evt.control_number == SUSTAIN_CTRL) &&
                  chan_ok;
    pedal_val   = (evt.control_value >= PEDAL_THRESHOLD);

    cmd.note_on   = (evt.action == ACT_NOTE_ON);
    cmd.note_off  = (evt.action == ACT_NOTE_OFF);
    cmd.pedal_set = ctl_sustain && pedal_val;
    cmd.pedal_clr = ctl_sustain && !pedal_val;
    cmd.pedal     = chan_ok && pedal_cur;
    cmd.channel   = evt.channel;
    cmd.note      = evt.note_number;
  end

  always_comb begin
    dup = 1'b0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      dup = dup || stat[v].dup_hit;
    end
  end

  assign taken[0] = 1'b0;

  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
    svalloc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .apply     (accept),
      .cmd       (cmd),
      .dup       (dup),
      .taken_in  (taken[g]),
      .taken_out (taken[g+1]),
      .stat      (stat[g])
    );
  end

  always_comb begin
    pick          = '0;
    changed_next  = '0;
    sounding_next = '0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (stat[v].claim) begin
        pick = VIDX_W'(v);
      end
      if (v < MASK_W) begin
        changed_next[v]  = stat[v].changed;
        sounding_next[v] = stat[v].sounding;
      end
    end

    case (evt.action)
      ACT_NOTE_ON: begin
        if (dup) begin
          status_next = ST_DUPLICATE;
        end else if (taken[NUM_VOICES]) begin
          status_next = ST_STARTED;
        end else begin
          status_next = ST_NO_VOICE;
        end
      end
      ACT_NOTE_OFF: status_next = ST_RELEASED;
      default: status_next = ctl_sustain ? ST_SUSTAIN : ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_down <= '0;
      res.valid  <= 1'b0;
    end else begin
      if (accept) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (accept && ctl_sustain && (evt.channel == CHANNEL_W'(c))) begin
          pedal_down[c] <= pedal_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.status        <= status_next;
      res.voice_index   <= (status_next == ST_STARTED) ?
                           INDEX_W'({{INDEX_W{1'b0}}, pick}) : '0;
      res.changed_mask  <= changed_next;
      res.sounding_mask <= sounding_next;
    end
  end

  a_start_onehot: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status == ST_STARTED) |-> $onehot0(res.changed_mask))
    else $error("started voice changed more than one voice");

  a_start_sounds: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status == ST_STARTED) |->
      ((res.changed_mask & ~res.sounding_mask) == '0))
    else $error("started voice is not sounding");

  a_no_change: assert property (@(posedge clk) disable iff (rst)
    res.valid && ((res.status == ST_DUPLICATE) || (res.status == ST_NO_VOICE) ||
                  (res.status == ST_IGNORED)) |->
      (res.changed_mask == '0) && (res.voice_index == '0))
    else $error("state changed on an event without effect");

  a_full_when_none: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.note_on && !dup && !taken[NUM_VOICES] |=>
      (res.status == ST_NO_VOICE))
    else $error("no-voice status lost");

endmodule
